### hw/rtl/rhc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_pkg: shared types and constants for the RGB to HSV converter
// Pixel widths, hue scale, divider geometry and the item that travels
// through the divider pipeline.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned HUE_W      = 15;
  // Quotient bits: hue fraction is at most 3840, saturation at most 255.
  localparam int unsigned QUO_W      = 12;
  localparam int unsigned NUM_W      = PIX_W + QUO_W;
  localparam int unsigned DIV_STEPS  = 3;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_STEPS;

  localparam logic [HUE_W-1:0] HUE_SIXTH     = 15'd3840;
  localparam logic [HUE_W-1:0] HUE_OFS_GREEN = 15'd7680;
  localparam logic [HUE_W-1:0] HUE_OFS_BLUE  = 15'd15360;
  localparam logic [HUE_W-1:0] HUE_FULL      = 15'd23040;

  typedef logic [PIX_W-1:0] pix_t;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  // One restoring-division lane: partial remainder, numerator bits still
  // to shift in, and quotient bits gathered so far.
  typedef struct packed {
    pix_t             den;
    pix_t             rem;
    logic [QUO_W-1:0] num_lo;
    logic [QUO_W-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    pix_t      bright;
    logic      gray;
    sector_t   sector;
    logic      neg;
    div_lane_t hue;
    div_lane_t sat;
  } div_item_t;

endpackage

`default_nettype wire

### hw/rtl/rhc_rgb_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_rgb_if: RGB pixel channel
// Valid/ready channel carrying one 8-bit red, green and blue pixel.
// ----------------------------------------------------------------------------
interface rhc_rgb_if;

  logic          valid;
  logic          ready;
  rhc_pkg::pix_t red;
  rhc_pkg::pix_t green;
  rhc_pkg::pix_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

`default_nettype wire

### hw/rtl/rhc_hsv_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_hsv_if: HSV pixel channel
// Valid/ready channel carrying hue, saturation and brightness.
// ----------------------------------------------------------------------------
interface rhc_hsv_if;

  logic                        valid;
  logic                        ready;
  logic [rhc_pkg::HUE_W-1:0]   hue;
  rhc_pkg::pix_t               saturation;
  rhc_pkg::pix_t               brightness;

  modport source (output valid, output hue, output saturation, output brightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness,
                  output ready);

endinterface

`default_nettype wire

### hw/rtl/rhc_div_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rhc_div_stage: one register stage of the pipelined divider
// Runs a few restoring-division steps on both the hue and the saturation
// lane, then registers the item. Holds its item while downstream stalls.
// ----------------------------------------------------------------------------
module rhc_div_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                valid_i,
  input  rhc_pkg::div_item_t  item_i,
  output logic                ready_o,
  output logic                valid_o,
  output rhc_pkg::div_item_t  item_o,
  input  logic                ready_i
);
  import rhc_pkg::*;

  logic      valid_r, valid_nxt;
  div_item_t item_r, item_nxt;

  // Shift one numerator bit into the remainder, subtract when it fits.
  function automatic div_lane_t div_step(div_lane_t l);
    logic [PIX_W:0] part;
    div_lane_t      o;
    o        = l;
    part     = {l.rem, l.num_lo[QUO_W-1]};
    o.num_lo = {l.num_lo[QUO_W-2:0], 1'b0};
    if (part >= {1'b0, l.den}) begin
      o.rem = PIX_W'(part - {1'b0, l.den});
      o.quo = {l.quo[QUO_W-2:0], 1'b1};
    end else begin
      o.rem = part[PIX_W-1:0];
      o.quo = {l.quo[QUO_W-2:0], 1'b0};
    end
    return o;
  endfunction

  assign ready_o = !valid_r || ready_i;
  assign valid_o = valid_r;
  assign item_o  = item_r;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (ready_o) begin
      valid_nxt = valid_i;
      item_nxt  = item_i;
      for (int i = 0; i < DIV_STEPS; i++) begin
        item_nxt.hue = div_step(item_nxt.hue);
        item_nxt.sat = div_step(item_nxt.sat);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

endmodule

`default_nettype wire

### hw/rtl/rgb_to_hsv_convert_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_convert_unit: streaming RGB to HSV pixel converter
// Turns one 8-bit RGB pixel into hue, saturation and brightness.
// ----------------------------------------------------------------------------
// Takes one pixel per clock unless the output stalls, and returns one HSV
// item per pixel, in order. Brightness is the largest channel;
// saturation is floor(delta*255/max), delta being max minus min; hue is in
// 1/64 degree (0..23039, 3840 per sixth of the circle), taken from the
// sector of the largest channel with ties going red, then green, then
// blue. Gray pixels, black included, give hue and saturation of zero.
// The pipeline centres on the twelve-bit restoring divider, run as four
// register stages of three quotient bits each, for hue and saturation side
// by side; add one stage for max/min, one for numerators, one for the
// output register. Each stage holds its item while the next one is full
// and stalled, so a bubble anywhere is filled and a stall on the output
// loses or repeats nothing. The block keeps no state between pixels.
// ----------------------------------------------------------------------------
module rgb_to_hsv_convert_unit (
  input  logic      clk,
  input  logic      rst_n,
  rhc_rgb_if.sink   in_pix,
  rhc_hsv_if.source out_pix
);
  import rhc_pkg::*;

  // Stage 1 payload: extremes, sector and the signed hue difference.
  pix_t    s1_max_r, s1_max_nxt;
  pix_t    s1_min_r, s1_min_nxt;
  pix_t    s1_dmag_r, s1_dmag_nxt;
  logic    s1_neg_r, s1_neg_nxt;
  sector_t s1_sec_r, s1_sec_nxt;
  logic    s1_v_r, s1_v_nxt;
  logic    s1_adv;

  // Stage 2: divider item with numerators and divisors loaded.
  div_item_t s2_r, s2_nxt;
  logic      s2_v_r, s2_v_nxt;
  logic      s2_adv;

  // Divider chain handshake, index k feeds stage k.
  logic      div_valid [DIV_STAGES+1];
  logic      div_ready [DIV_STAGES+1];
  div_item_t div_item  [DIV_STAGES+1];

  // Output register.
  logic             out_v_r, out_v_nxt;
  logic [HUE_W-1:0] out_hue_r, out_hue_nxt;
  pix_t             out_sat_r, out_sat_nxt;
  pix_t             out_bright_r, out_bright_nxt;
  logic             out_adv;

  div_item_t        fin;
  logic [HUE_W-1:0] fin_frac;
  logic [HUE_W-1:0] fin_ofs;

  // --------------------------------------------------------------------------
  // Stage 1: max, min and the sector of the largest channel
  // --------------------------------------------------------------------------
  assign s1_adv       = !s1_v_r || s2_adv;
  assign in_pix.ready = s1_adv;

  always_comb begin
    s1_v_nxt    = s1_v_r;
    s1_max_nxt  = s1_max_r;
    s1_min_nxt  = s1_min_r;
    s1_sec_nxt  = s1_sec_r;
    s1_neg_nxt  = s1_neg_r;
    s1_dmag_nxt = s1_dmag_r;
    if (s1_adv) begin
      s1_v_nxt   = in_pix.valid;
      s1_max_nxt = in_pix.red;
      s1_min_nxt = in_pix.red;
      if (in_pix.green > s1_max_nxt) s1_max_nxt = in_pix.green;
      if (in_pix.blue  > s1_max_nxt) s1_max_nxt = in_pix.blue;
      if (in_pix.green < s1_min_nxt) s1_min_nxt = in_pix.green;
      if (in_pix.blue  < s1_min_nxt) s1_min_nxt = in_pix.blue;
      // Ties go red, then green; the difference is taken as sign and size.
      if (in_pix.red >= in_pix.green && in_pix.red >= in_pix.blue) begin
        s1_sec_nxt  = SEC_RED;
        s1_neg_nxt  = in_pix.green < in_pix.blue;
        s1_dmag_nxt = s1_neg_nxt ? in_pix.blue - in_pix.green
                                 : in_pix.green - in_pix.blue;
      end else if (in_pix.green >= in_pix.blue) begin
        s1_sec_nxt  = SEC_GREEN;
        s1_neg_nxt  = in_pix.blue < in_pix.red;
        s1_dmag_nxt = s1_neg_nxt ? in_pix.red - in_pix.blue
                                 : in_pix.blue - in_pix.red;
      end else begin
        s1_sec_nxt  = SEC_BLUE;
        s1_neg_nxt  = in_pix.red < in_pix.green;
        s1_dmag_nxt = s1_neg_nxt ? in_pix.green - in_pix.red
                                 : in_pix.red - in_pix.green;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: delta, numerators 3840*|diff| and 255*delta, divisors
  // --------------------------------------------------------------------------
  assign s2_adv = !s2_v_r || div_ready[0];

  always_comb begin
    pix_t             delta;
    logic [NUM_W-1:0] hue_num;
    logic [NUM_W-1:0] sat_num;
    s2_v_nxt = s2_v_r;
    s2_nxt   = s2_r;
    delta    = s1_max_r - s1_min_r;
    // 3840 = 4096 - 256, 255 = 256 - 1
    hue_num  = {s1_dmag_r, 12'b0} - NUM_W'({s1_dmag_r, 8'b0});
    sat_num  = NUM_W'({delta, 8'b0}) - NUM_W'(delta);
    if (s2_adv) begin
      s2_v_nxt          = s1_v_r;
      s2_nxt.bright     = s1_max_r;
      s2_nxt.gray       = (delta == '0);
      s2_nxt.sector     = s1_sec_r;
      s2_nxt.neg        = s1_neg_r;
      // A gray pixel has zero numerators; divide by one to keep it defined.
      s2_nxt.hue.den    = s2_nxt.gray ? PIX_W'(1) : delta;
      s2_nxt.hue.rem    = hue_num[NUM_W-1:QUO_W];
      s2_nxt.hue.num_lo = hue_num[QUO_W-1:0];
      s2_nxt.hue.quo    = '0;
      s2_nxt.sat.den    = s2_nxt.gray ? PIX_W'(1) : s1_max_r;
      s2_nxt.sat.rem    = sat_num[NUM_W-1:QUO_W];
      s2_nxt.sat.num_lo = sat_num[QUO_W-1:0];
      s2_nxt.sat.quo    = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Divider: restoring division, a few quotient bits per stage
  // --------------------------------------------------------------------------
  assign div_valid[0] = s2_v_r;
  assign div_item[0]  = s2_r;

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    rhc_div_stage u_div_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (div_valid[k]),
      .item_i  (div_item[k]),
      .ready_o (div_ready[k]),
      .valid_o (div_valid[k+1]),
      .item_o  (div_item[k+1]),
      .ready_i (div_ready[k+1])
    );
  end

  // --------------------------------------------------------------------------
  // Output stage: add sector offset, wrap negative hue, register result
  // --------------------------------------------------------------------------
  assign fin                   = div_item[DIV_STAGES];
  assign out_adv               = !out_v_r || out_pix.ready;
  assign div_ready[DIV_STAGES] = out_adv;
  assign fin_frac              = HUE_W'(fin.hue.quo);

  always_comb begin
    case (fin.sector)
      SEC_GREEN: fin_ofs = HUE_OFS_GREEN;
      SEC_BLUE:  fin_ofs = HUE_OFS_BLUE;
      default:   fin_ofs = '0;
    endcase
  end

  always_comb begin
    out_v_nxt      = out_v_r;
    out_hue_nxt    = out_hue_r;
    out_sat_nxt    = out_sat_r;
    out_bright_nxt = out_bright_r;
    if (out_adv) begin
      out_v_nxt      = div_valid[DIV_STAGES];
      out_bright_nxt = fin.bright;
      out_sat_nxt    = fin.sat.quo[PIX_W-1:0];
      if (fin.gray) begin
        out_hue_nxt = '0;
      end else if (!fin.neg) begin
        out_hue_nxt = fin_ofs + fin_frac;
      end else if (fin.sector == SEC_RED) begin
        // Only the red sector can go below zero: wrap by a full circle.
        out_hue_nxt = HUE_FULL - fin_frac;
      end else begin
        out_hue_nxt = fin_ofs - fin_frac;
      end
    end
  end

  assign out_pix.valid      = out_v_r;
  assign out_pix.hue        = out_hue_r;
  assign out_pix.saturation = out_sat_r;
  assign out_pix.brightness = out_bright_r;

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_max_r     <= s1_max_nxt;
    s1_min_r     <= s1_min_nxt;
    s1_sec_r     <= s1_sec_nxt;
    s1_neg_r     <= s1_neg_nxt;
    s1_dmag_r    <= s1_dmag_nxt;
    s2_r         <= s2_nxt;
    out_hue_r    <= out_hue_nxt;
    out_sat_r    <= out_sat_nxt;
    out_bright_r <= out_bright_nxt;
  end

endmodule

`default_nettype wire

### tb/sv/hsv_checker.sv
// ----------------------------------------------------------------------------
// hsv_checker: result predictor and scoreboard for the RGB to HSV converter
// Watches both pixel channels, computes the HSV value of every accepted RGB
// pixel and compares it field by field with the results in arrival order.
// ----------------------------------------------------------------------------
module hsv_checker (
  input  logic clk,
  input  logic rst_n,
  rhc_rgb_if   rgb_mon,
  rhc_hsv_if   hsv_mon,
  output int   fail_count,
  output int   pending,
  output int   checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import rhc_pkg::*;

  localparam int SIXTH_UNITS = int'(HUE_SIXTH);
  localparam int CIRCLE_UNITS = int'(HUE_FULL);

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    pix_t             saturation;
    pix_t             brightness;
  } hsv_t;

  hsv_t hsv_expected_q[$];

  function automatic hsv_t hsv_of_rgb(pix_t red, pix_t green, pix_t blue);
    int      r;
    int      g;
    int      b;
    int      top;
    int      bottom;
    int      delta;
    int      angle;
    int      sat;
    sector_t sector;
    hsv_t    res;
    r = int'(red);
    g = int'(green);
    b = int'(blue);
    top = r;
    bottom = r;
    if (g > top) top = g;
    if (b > top) top = b;
    if (g < bottom) bottom = g;
    if (b < bottom) bottom = b;
    delta = top - bottom;
    angle = 0;
    sat = 0;
    if (delta > 0) begin
      sat = (delta * 255) / top;
      // ties go red, then green, then blue
      if (r == top) sector = SEC_RED;
      else if (g == top) sector = SEC_GREEN;
      else sector = SEC_BLUE;
      case (sector)
        SEC_RED:   angle = (SIXTH_UNITS * (g - b)) / delta;
        SEC_GREEN: angle = 2 * SIXTH_UNITS + (SIXTH_UNITS * (b - r)) / delta;
        default:   angle = 4 * SIXTH_UNITS + (SIXTH_UNITS * (r - g)) / delta;
      endcase
      if (angle < 0) angle += CIRCLE_UNITS;
    end
    res.hue = angle[HUE_W-1:0];
    res.saturation = sat[PIX_W-1:0];
    res.brightness = top[PIX_W-1:0];
    return res;
  endfunction

  function automatic int field_miss(string name, int want, int seen);
    if (want == seen) return 0;
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
    return 1;
  endfunction

  initial begin
    fail_count <= 0;
    pending <= 0;
    checked_count <= 0;
  end

  always @(posedge clk) begin
    hsv_t want;
    hsv_t seen;
    int   misses;
    misses = 0;
    if (rst_n) begin
      if (rgb_mon.valid && rgb_mon.ready) begin
        hsv_expected_q.push_back(hsv_of_rgb(rgb_mon.red, rgb_mon.green, rgb_mon.blue));
      end
      if (hsv_mon.valid && hsv_mon.ready) begin
        seen.hue = hsv_mon.hue;
        seen.saturation = hsv_mon.saturation;
        seen.brightness = hsv_mon.brightness;
        if (hsv_expected_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual hue=%0d sat=%0d val=%0d",
                   $time, seen.hue, seen.saturation, seen.brightness);
          misses = 1;
        end else begin
          want = hsv_expected_q.pop_front();
          misses += field_miss("hue", int'(want.hue), int'(seen.hue));
          misses += field_miss("saturation", int'(want.saturation), int'(seen.saturation));
          misses += field_miss("brightness", int'(want.brightness), int'(seen.brightness));
          checked_count <= checked_count + 1;
        end
      end
    end
    fail_count <= fail_count + misses;
    pending <= hsv_expected_q.size();
  end

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stream test of the RGB to HSV converter
// Feeds corner-case and random pixels in bursts against a stalling receiver,
// and lets the checker compare every HSV result with its own prediction.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rhc_pkg::*;

  localparam int RANDOM_ITEMS = 1880;
  localparam int FLOOD_ITEMS  = 48;    // items offered while the output is held off
  localparam int HOLD_CYCLES  = 200;
  localparam int TAIL_CYCLES  = 20;    // idle cycles after the last result has come back
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int N_CORNERS    = 24;

  // Corner pixels as {red, green, blue}.
  localparam logic [23:0] CORNER_PIX [N_CORNERS] = '{
    24'h000000,  // black
    24'hFFFFFF,  // white
    24'h808080,  // mid gray
    24'hFF0000,  // pure red
    24'h00FF00,  // pure green
    24'h0000FF,  // pure blue
    24'hFFFF00,  // red ties green
    24'h00FFFF,  // green ties blue
    24'hFF00FF,  // red ties blue
    24'hFF0001,  // red sector, hue wraps below zero
    24'hFE00FF,  // blue just above red
    24'h010000,  // smallest nonzero max
    24'h000100,
    24'h000001,
    24'hFFFEFE,  // delta of one at full scale
    24'h010100,
    24'hFEFF00,
    24'h00FEFF,
    24'hFF00FE,
    24'hC86432,
    24'h32C864,
    24'h6432C8,
    24'h7F8081,
    24'h010001
  };

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   items_sent;
  int   fail_count;
  int   pending;
  int   checked_count;
  bit   hold_req;

  rhc_rgb_if rgb_ch ();
  rhc_hsv_if hsv_ch ();

  rgb_to_hsv_convert_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (rgb_ch),
    .out_pix (hsv_ch)
  );

  hsv_checker scoreboard (
    .clk           (clk),
    .rst_n         (rst_n),
    .rgb_mon       (rgb_ch),
    .hsv_mon       (hsv_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .checked_count (checked_count)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Count cycles; the watchdog below ends a run that hangs.
  initial cycle_count <= 0;
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still outstanding", cycle_count, pending);
    $display("== FAIL ==");
    $finish;
  end

  // Offer one pixel and hold it until the block takes it.
  task automatic send_pixel(pix_t r, pix_t g, pix_t b);
    rgb_ch.valid <= 1'b1;
    rgb_ch.red   <= r;
    rgb_ch.green <= g;
    rgb_ch.blue  <= b;
    do @(posedge clk); while (!rgb_ch.ready);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come back.
  task automatic drain_results();
    rgb_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Pick a pixel: mostly uniform, with plenty of grays, near-grays and
  // ties or full-scale channels, where the sector and sign logic is tight.
  task automatic next_pixel(output pix_t r, output pix_t g, output pix_t b);
    int kind;
    int base;
    int ch[3];
    int k;
    kind = $urandom_range(99);
    if (kind < 55) begin
      for (k = 0; k < 3; k++) ch[k] = $urandom_range(255);
    end else if (kind < 65) begin
      base = $urandom_range(255);
      for (k = 0; k < 3; k++) ch[k] = base;
    end else if (kind < 80) begin
      base = $urandom_range(255);
      for (k = 0; k < 3; k++) begin
        ch[k] = base + $urandom_range(4) - 2;
        if (ch[k] < 0) ch[k] = 0;
        if (ch[k] > 255) ch[k] = 255;
      end
    end else begin
      for (k = 0; k < 3; k++) begin
        case ($urandom_range(3))
          0: ch[k] = 0;
          1: ch[k] = 255;
          default: ch[k] = $urandom_range(255);
        endcase
      end
      // force a tie for the largest channel now and then
      if ($urandom_range(1)) begin
        k = $urandom_range(2);
        ch[(k + 1) % 3] = ch[k];
      end
    end
    r = ch[0][7:0];
    g = ch[1][7:0];
    b = ch[2][7:0];
  endtask

  // Send random pixels in bursts separated by random gaps; about a quarter
  // of the bursts run straight into the next one with no gap at all.
  task automatic random_traffic(int count);
    pix_t r;
    pix_t g;
    pix_t b;
    int   burst;
    int   gap;
    int   done_cnt;
    done_cnt = 0;
    while (done_cnt < count) begin
      burst = $urandom_range(1, 40);
      while (burst > 0 && done_cnt < count) begin
        next_pixel(r, g, b);
        send_pixel(r, g, b);
        done_cnt++;
        burst--;
      end
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        rgb_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Receiver: switch between stall patterns after spans of random length;
  // on request hold ready low for a long stretch.
  initial begin
    int mode;
    int span;
    int duty;
    int period;
    int i;
    hsv_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        repeat (HOLD_CYCLES) begin
          hsv_ch.ready <= 1'b0;
          @(posedge clk);
        end
        hold_req = 1'b0;
      end else begin
        mode = $urandom_range(3);
        span = $urandom_range(20, 300);
        duty = $urandom_range(10, 90);
        period = $urandom_range(2, 9);
        for (i = 0; i < span && !hold_req; i++) begin
          case (mode)
            0: hsv_ch.ready <= 1'b1;
            1: hsv_ch.ready <= ($urandom_range(99) < duty);
            2: hsv_ch.ready <= ((i % period) != 0);
            default: hsv_ch.ready <= ((i % (2 * period)) < period);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Sender: reset, corner pixels, random bursts, a flood against the held
  // output, more random bursts, then the end of the run.
  initial begin
    pix_t r;
    pix_t g;
    pix_t b;
    int   k;
    items_sent = 0;
    hold_req = 1'b0;
    rst_n <= 1'b0;
    rgb_ch.valid <= 1'b0;
    rgb_ch.red   <= '0;
    rgb_ch.green <= '0;
    rgb_ch.blue  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Corner pixels back to back.
    for (k = 0; k < N_CORNERS; k++) begin
      send_pixel(CORNER_PIX[k][23:16], CORNER_PIX[k][15:8], CORNER_PIX[k][7:0]);
    end
    drain_results();

    random_traffic(RANDOM_ITEMS / 2);
    drain_results();

    // Hold the output off and keep offering items so the pipe fills and
    // backs up into the input.
    hold_req = 1'b1;
    repeat (FLOOD_ITEMS) begin
      next_pixel(r, g, b);
      send_pixel(r, g, b);
    end

    random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2 - FLOOD_ITEMS);

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d pixels (%0d corner cases, rest random in bursts), checked %0d results",
             items_sent, N_CORNERS, checked_count);
    $display("output held off once for %0d cycles under a full input; %0d mismatches",
             HOLD_CYCLES, fail_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
